// File: rtl/core/mcp_pkg.sv
// Shared types, status codes and decode helpers for the MIDI channel message parser.
package mcp_pkg;

  // High nibbles of channel status bytes
  localparam logic [3:0] ST_NOTE_OFF   = 4'h8;
  localparam logic [3:0] ST_NOTE_ON    = 4'h9;
  localparam logic [3:0] ST_POLY_AT    = 4'hA;
  localparam logic [3:0] ST_CTRL_CHG   = 4'hB;
  localparam logic [3:0] ST_PROG_CHG   = 4'hC;
  localparam logic [3:0] ST_CHAN_PRESS = 4'hD;
  localparam logic [3:0] ST_PITCH_BEND = 4'hE;
  localparam logic [3:0] ST_SYSTEM     = 4'hF;

  // Running status value meaning no status held
  localparam logic [7:0] NO_STATUS = 8'h00;

  // Event kinds reported on the result channel
  typedef enum logic [1:0] {
    EV_NOTE_OFF    = 2'd0,
    EV_NOTE_ON     = 2'd1,
    EV_CTRL_CHANGE = 2'd2,
    EV_PITCH_BEND  = 2'd3
  } mcp_kind_t;

  // Real-time bytes span F8 to FF
  function automatic logic is_realtime(input logic [7:0] b);
    return (b[7:3] == 5'b11111);
  endfunction

  // Messages with two data bytes
  function automatic logic is_two_byte(input logic [3:0] nib);
    logic res;
    unique case (nib) inside
      ST_NOTE_OFF, ST_NOTE_ON, ST_POLY_AT, ST_CTRL_CHG, ST_PITCH_BEND: res = 1'b1;
      default:                                                         res = 1'b0;
    endcase
    return res;
  endfunction

endpackage

// File: rtl/core/midi_channel_message_parser_unit.sv
// MIDI channel message parser with running status: input register, decode, event register.
//
// Usage:
//   Input channel rx_valid / rx_ready carries one received MIDI byte (rx_byte)
//   per transaction. Status bytes have bit 7 set; real-time bytes (F8 to FF)
//   are ignored, other system bytes clear the running status, channel status
//   bytes set it. Complete note off, note on, control change and pitch bend
//   messages produce one transaction on the event channel ev_valid / ev_ready
//   carrying event_kind, channel, first_data and second_data. A note on with
//   zero velocity is reported as a note off. Other messages produce nothing.
// Path: a byte accepted into the input register is decoded combinationally, and
//   its event is loaded into the event register when the decode stage advances.
// Throughput: one byte per cycle while no event waits on ev_ready; the single decode
//   stage between the input and event registers updates the parser state per decoded byte.
// Reset (rst, synchronous): both registers empty, running status cleared,
//   data byte count and held first data byte cleared.
// Stall: while an event waits on ev_ready, the input register still takes one
//   more byte; further bytes are refused until the event is taken.
module midi_channel_message_parser_unit
  import mcp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       rx_valid,
  output logic       rx_ready,
  input  logic [7:0] rx_byte,
  output logic       ev_valid,
  input  logic       ev_ready,
  output logic [1:0] event_kind,
  output logic [3:0] channel,
  output logic [6:0] first_data,
  output logic [6:0] second_data
);

  // Input register
  logic       in_full;
  logic [7:0] in_byte;

  // Parser state
  logic [7:0] cur_status, cur_status_next;
  logic       bytes_received, bytes_received_next;
  logic [6:0] held_first_byte, held_first_byte_next;

  // Event register
  mcp_kind_t  ev_kind, ev_kind_next;
  logic [3:0] ev_chan;
  logic [6:0] ev_first, ev_second;
  logic       emit;
  logic       advance;

  // Decode stage fires when the event register can take its outcome
  assign advance  = in_full && (!ev_valid || ev_ready);
  assign rx_ready = !in_full || advance;

  // Hold the incoming byte
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (rx_ready) begin
      in_full <= rx_valid;
    end
    if (rx_valid && rx_ready) begin
      in_byte <= rx_byte;
    end
  end

  // Decode one byte against the running status
  always_comb begin
    cur_status_next      = cur_status;
    bytes_received_next  = bytes_received;
    held_first_byte_next = held_first_byte;
    emit                 = 1'b0;
    ev_kind_next         = EV_NOTE_OFF;
    if (is_realtime(in_byte)) begin
      emit = 1'b0;
    end else if (in_byte[7]) begin
      bytes_received_next = 1'b0;
      cur_status_next     = (in_byte[7:4] == ST_SYSTEM) ? NO_STATUS : in_byte;
    end else if (cur_status != NO_STATUS) begin
      if (!bytes_received) begin
        held_first_byte_next = in_byte[6:0];
        bytes_received_next  = is_two_byte(cur_status[7:4]);
      end else begin
        bytes_received_next = 1'b0;
        unique case (cur_status[7:4])
          ST_NOTE_OFF: begin
            emit         = 1'b1;
            ev_kind_next = EV_NOTE_OFF;
          end
          ST_NOTE_ON: begin
            emit         = 1'b1;
            ev_kind_next = (in_byte[6:0] == 7'd0) ? EV_NOTE_OFF : EV_NOTE_ON;
          end
          ST_CTRL_CHG: begin
            emit         = 1'b1;
            ev_kind_next = EV_CTRL_CHANGE;
          end
          ST_PITCH_BEND: begin
            emit         = 1'b1;
            ev_kind_next = EV_PITCH_BEND;
          end
          default: begin
            emit = 1'b0;
          end
        endcase
      end
    end
  end

  // Advance parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_status      <= NO_STATUS;
      bytes_received  <= 1'b0;
      held_first_byte <= 7'd0;
    end else if (advance) begin
      cur_status      <= cur_status_next;
      bytes_received  <= bytes_received_next;
      held_first_byte <= held_first_byte_next;
    end
  end

  // Event register: load on decode, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      ev_valid <= 1'b0;
    end else if (advance) begin
      ev_valid <= emit;
    end else if (ev_ready) begin
      ev_valid <= 1'b0;
    end
    if (advance && emit) begin
      ev_kind   <= ev_kind_next;
      ev_chan   <= cur_status[3:0];
      ev_first  <= held_first_byte;
      ev_second <= in_byte[6:0];
    end
  end

  assign event_kind  = ev_kind;
  assign channel     = ev_chan;
  assign first_data  = ev_first;
  assign second_data = ev_second;

`ifndef SYNTHESIS
  // A pending second data byte needs a two-byte channel status
  a_count_needs_status: assert property (@(posedge clk) disable iff (rst)
    bytes_received |-> (cur_status[7] && is_two_byte(cur_status[7:4])))
    else $error("data byte count set without a two-byte running status");

  // Running status is either empty or a channel status byte
  a_status_is_channel: assert property (@(posedge clk) disable iff (rst)
    (cur_status != NO_STATUS) |->
      (cur_status[7] && cur_status[7:4] != ST_SYSTEM))
    else $error("running status holds a non-channel byte");

  // A new event appears only from a decode step
  a_event_from_decode: assert property (@(posedge clk) disable iff (rst)
    $rose(ev_valid) |-> $past(advance))
    else $error("event raised without a decode step");

  // Zero velocity never leaves as a note on
  a_note_on_velocity: assert property (@(posedge clk) disable iff (rst)
    (ev_valid && ev_kind == EV_NOTE_ON) |-> (ev_second != 7'd0))
    else $error("note on reported with zero velocity");
`endif

endmodule

// File: bench/tb.sv
// Self-checking bench for the MIDI running-status parser with random handshake gaps.
`timescale 1ns / 100ps

module tb;
  import mcp_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int ITEMS_PER_PHASE = 300;
  localparam int PHASES = 4;
  localparam int MAX_GAP = 17;

  // One decoded channel event as it appears on the result ports
  typedef struct packed {
    mcp_kind_t  kind;
    logic [3:0] chan;
    logic [6:0] data1;
    logic [6:0] data2;
  } chan_event_t;

  // Running-status parser model with its queue of events still owed
  class midi_event_predictor;
    logic [7:0]  status_reg;
    logic        have_first;
    logic [6:0]  first_reg;
    chan_event_t owed_events[$];
    int          errors;

    function new();
      status_reg = NO_STATUS;
      have_first = 1'b0;
      first_reg  = '0;
      errors     = 0;
    endfunction

    function int pending();
      return owed_events.size();
    endfunction

    // Advance the parser state by one accepted byte
    function void absorb_byte(logic [7:0] b);
      chan_event_t ev;
      logic        emit;
      emit = 1'b0;
      if (b[7:3] == 5'b11111) begin
        // real-time byte: leave everything alone
      end else if (b[7]) begin
        have_first = 1'b0;
        status_reg = (b[7:4] == ST_SYSTEM) ? NO_STATUS : b;
      end else if (status_reg != NO_STATUS) begin
        case (status_reg[7:4])
          ST_PROG_CHG, ST_CHAN_PRESS: begin
            first_reg = b[6:0];
          end
          ST_NOTE_OFF, ST_NOTE_ON, ST_POLY_AT, ST_CTRL_CHG, ST_PITCH_BEND: begin
            if (!have_first) begin
              first_reg  = b[6:0];
              have_first = 1'b1;
            end else begin
              have_first = 1'b0;
              ev.chan  = status_reg[3:0];
              ev.data1 = first_reg;
              ev.data2 = b[6:0];
              emit     = 1'b1;
              case (status_reg[7:4])
                ST_NOTE_OFF:   ev.kind = EV_NOTE_OFF;
                ST_NOTE_ON:    ev.kind = (b[6:0] == 7'd0) ? EV_NOTE_OFF : EV_NOTE_ON;
                ST_CTRL_CHG:   ev.kind = EV_CTRL_CHANGE;
                ST_PITCH_BEND: ev.kind = EV_PITCH_BEND;
                default:       emit = 1'b0;
              endcase
            end
          end
          default: begin
            have_first = 1'b0;
          end
        endcase
      end
      if (emit) owed_events.push_back(ev);
    endfunction

    // Compare one event transaction with the oldest owed event
    function void compare_event(logic [1:0] kind, logic [3:0] chan,
                                logic [6:0] data1, logic [6:0] data2);
      chan_event_t ev;
      if (owed_events.size() == 0) begin
        $display("%0t: unexpected event kind %0d chan %0d data %0d %0d",
                 $time, kind, chan, data1, data2);
        errors++;
        return;
      end
      ev = owed_events.pop_front();
      if (kind !== ev.kind) begin
        $display("%0t: event_kind expected %0d actual %0d", $time, ev.kind, kind);
        errors++;
      end
      if (chan !== ev.chan) begin
        $display("%0t: channel expected %0d actual %0d", $time, ev.chan, chan);
        errors++;
      end
      if (data1 !== ev.data1) begin
        $display("%0t: first_data expected %0d actual %0d", $time, ev.data1, data1);
        errors++;
      end
      if (data2 !== ev.data2) begin
        $display("%0t: second_data expected %0d actual %0d", $time, ev.data2, data2);
        errors++;
      end
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       rx_valid;
  logic       rx_ready;
  logic [7:0] rx_byte;
  logic       ev_valid;
  logic       ev_ready;
  logic [1:0] event_kind;
  logic [3:0] channel;
  logic [6:0] first_data;
  logic [6:0] second_data;

  midi_event_predictor parser_model;
  int  cycle_count;
  int  items_sent;
  int  ev_stall;
  bit  tx_calm;
  bit  rx_calm;
  logic [7:0] gen_status;

  midi_channel_message_parser_unit dut (
    .clk        (clk),
    .rst        (rst),
    .rx_valid   (rx_valid),
    .rx_ready   (rx_ready),
    .rx_byte    (rx_byte),
    .ev_valid   (ev_valid),
    .ev_ready   (ev_ready),
    .event_kind (event_kind),
    .channel    (channel),
    .first_data (first_data),
    .second_data(second_data)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  function automatic int draw_gap(bit calm);
    if (calm) return 0;
    if ($urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, MAX_GAP);
  endfunction

  // Favour the extremes of a data byte
  function automatic logic [7:0] data_value();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'h7F;
      default: return 8'($urandom_range(0, 127));
    endcase
  endfunction

  // Sample both channels at the rising edge
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
    if (!rst) begin
      if (rx_valid && rx_ready) parser_model.absorb_byte(rx_byte);
      if (ev_valid && ev_ready) begin
        parser_model.compare_event(event_kind, channel, first_data, second_data);
        ev_stall = draw_gap(rx_calm);
      end
    end
  end

  // Drive ev_ready: hold low for the drawn stall, then high until a transaction
  always @(negedge clk) begin
    if (rst) begin
      ev_ready <= 1'b0;
    end else if (ev_stall > 0) begin
      ev_ready <= 1'b0;
      ev_stall--;
    end else begin
      ev_ready <= 1'b1;
    end
  end

  // Present one byte after a gap; return at the falling edge after acceptance
  task automatic send_byte(logic [7:0] b);
    int gap;
    gap = draw_gap(tx_calm);
    if (gap > 0) begin
      rx_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    rx_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (!rx_ready);
    @(negedge clk);
    if (b[7:3] != 5'b11111) items_sent++;
    if (b[7] && b[7:3] != 5'b11111) gen_status = (b[7:4] == ST_SYSTEM) ? NO_STATUS : b;
  endtask

  // Pause the sender until every owed event has come out
  task automatic drain_events();
    rx_valid <= 1'b0;
    while (parser_model.pending() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic run_directed();
    logic [7:0] seq[$];
    seq = '{8'h40, 8'h00, 8'h90, 8'h3C, 8'h64, 8'h9F, 8'h7F, 8'h00,
            8'h80, 8'h7F, 8'h7F, 8'hB5, 8'h07, 8'h7F, 8'hE0, 8'h00, 8'h40,
            8'hA3, 8'h10, 8'h20, 8'hC2, 8'h05, 8'h06, 8'hD1, 8'h40,
            8'h90, 8'h3C, 8'hF8, 8'h64, 8'hFF, 8'h41, 8'h00,
            8'hF0, 8'h12, 8'hF7, 8'h90, 8'h3C, 8'hBE, 8'h07, 8'h10};
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  // Send one message, now and then with a real-time byte or cut short
  task automatic send_message();
    logic [3:0] nib;
    int         len;
    logic [7:0] d;
    if (gen_status == NO_STATUS || $urandom_range(0, 2) == 0) begin
      nib = 4'($urandom_range(int'(ST_NOTE_OFF), int'(ST_PITCH_BEND)));
      send_byte({nib, 4'($urandom_range(0, 15))});
    end
    nib = gen_status[7:4];
    len = (nib == ST_PROG_CHG || nib == ST_CHAN_PRESS) ? 1 : 2;
    if (len == 2 && $urandom_range(0, 9) == 0) len = 1;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) send_byte(8'($urandom_range(8'hF8, 8'hFF)));
      d = data_value();
      if (nib == ST_NOTE_ON && i == 1 && $urandom_range(0, 3) == 0) d = 8'h00;
      send_byte(d);
    end
  endtask

  task automatic send_noise();
    case ($urandom_range(0, 2))
      0:       send_byte(8'($urandom_range(0, 255)));
      1:       send_byte(8'($urandom_range(8'hF0, 8'hF7)));
      default: send_byte(data_value());
    endcase
  endtask

  initial begin
    parser_model = new();
    cycle_count = 0;
    items_sent  = 0;
    ev_stall    = 0;
    tx_calm     = 1'b0;
    rx_calm     = 1'b0;
    gen_status  = NO_STATUS;
    rst         = 1'b1;
    rx_valid    = 1'b0;
    rx_byte     = 8'h00;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    run_directed();
    drain_events();

    // Random phases: the first without idling, the others with random pacing
    for (int phase = 0; phase < PHASES; phase++) begin
      tx_calm = (phase == 0) ? 1'b1 : 1'($urandom_range(0, 3) == 0);
      rx_calm = (phase == 0) ? 1'b1 : 1'($urandom_range(0, 3) == 0);
      items_sent = 0;
      while (items_sent < ITEMS_PER_PHASE) begin
        if ($urandom_range(0, 7) == 0) send_noise();
        else send_message();
      end
      drain_events();
    end

    if (parser_model.pending() != 0) begin
      $display("%0t: %0d events never arrived", $time, parser_model.pending());
      parser_model.errors++;
    end
    if (parser_model.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: midi_channel_message_parser_unit.f
rtl/core/mcp_pkg.sv
rtl/core/midi_channel_message_parser_unit.sv
bench/tb.sv
